FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_FIN  = 4'd5,
    PH_WB0  = 4'd6,
    PH_WB1  = 4'd7,
    PH_WB2  = 4'd8,
    PH_WA0  = 4'd9,
    PH_WA1  = 4'd10,
    PH_WA2  = 4'd11,
    PH_RB1  = 4'd12,
    PH_RB2  = 4'd13,
    PH_RA1  = 4'd14,
    PH_RA2  = 4'd15
  } phase_t;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  localparam logic [7:0] SHORT_RESET   = 8'd2;
  localparam logic [7:0] LONG_RESET    = 8'd5;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] short_ticks;
    logic [7:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_received;
  } res_t;

  // a wait of w ticks counts the tick of the change, zero acts as one
  function automatic logic [7:0] wait_load(input logic [7:0] ticks);
    return (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
  endfunction

endpackage

FILE: rtl/i2cm_if.sv
interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, operation, tx_byte, send_ack, sda_sample, input ready);
  modport sink (input valid, operation, tx_byte, send_ack, sda_sample, output ready);
endinterface

interface i2cm_report_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_received;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  nack_received, input ready);
  modport sink (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                nack_received, output ready);
endinterface

FILE: rtl/i2cm_cfg.sv
module i2cm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output i2cm_pkg::cfg_t      cfg
);
  import i2cm_pkg::*;

  logic [7:0] short_ticks;
  logic [7:0] long_ticks;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_RESET;
      long_ticks  <= LONG_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SHORT: short_ticks <= pwdata[7:0];
        REG_LONG:  long_ticks  <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SHORT: prdata = {24'd0, short_ticks};
      REG_LONG:  prdata = {24'd0, long_ticks};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg.short_ticks = short_ticks;
  assign cfg.long_ticks  = long_ticks;

endmodule

FILE: rtl/i2cm_seq.sv
module i2cm_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  i2cm_pkg::cmd_t cmd,
  input  i2cm_pkg::cfg_t cfg,
  output i2cm_pkg::res_t res
);
  import i2cm_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] wait_count, wait_count_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       ack_flag, ack_flag_next;
  logic       scl_out, scl_out_next;
  logic       sda_out, sda_out_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       ack_latch, ack_latch_next;
  logic       done_next;

  logic       run;
  phase_t     act_ph;
  logic [7:0] act_shift;
  logic [3:0] bit_inc;
  logic [7:0] short_load;
  logic [7:0] long_load;

  assign short_load = wait_load(cfg.short_ticks);
  assign long_load  = wait_load(cfg.long_ticks);
  assign bit_inc    = bit_index + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= 8'd0;
      bit_index  <= 4'd0;
      shift_reg  <= 8'd0;
      ack_flag   <= 1'b0;
      scl_out    <= 1'b1;
      sda_out    <= 1'b1;
      rx_hold    <= 8'd0;
      ack_latch  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      ack_flag   <= ack_flag_next;
      scl_out    <= scl_out_next;
      sda_out    <= sda_out_next;
      rx_hold    <= rx_hold_next;
      ack_latch  <= ack_latch_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    ack_flag_next   = ack_flag;
    scl_out_next    = scl_out;
    sda_out_next    = sda_out;
    rx_hold_next    = rx_hold;
    ack_latch_next  = ack_latch;
    done_next       = 1'b0;
    run             = 1'b0;
    act_ph          = phase;
    act_shift       = shift_reg;

    if (phase == PH_IDLE) begin
      case (cmd.operation)
        OP_START: begin
          bit_index_next  = 4'd0;
          sda_out_next    = 1'b1;
          scl_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_ST1;
        end
        OP_STOP: begin
          bit_index_next  = 4'd0;
          scl_out_next    = 1'b0;
          sda_out_next    = 1'b0;
          wait_count_next = long_load;
          phase_next      = PH_SP1;
        end
        OP_WRITE: begin
          // first data bit goes out on the tick the command is taken
          bit_index_next = 4'd0;
          run            = 1'b1;
          act_ph         = PH_WB0;
          act_shift      = cmd.tx_byte;
        end
        OP_READ: begin
          bit_index_next  = 4'd0;
          ack_latch_next  = cmd.send_ack;
          shift_reg_next  = 8'd0;
          scl_out_next    = 1'b0;
          sda_out_next    = 1'b1;
          wait_count_next = short_load;
          phase_next      = PH_RB1;
        end
        default: ;
      endcase
    end else if (wait_count != 8'd0) begin
      wait_count_next = wait_count - 8'd1;
    end else begin
      run = 1'b1;
    end

    if (run) begin
      unique case (act_ph)
        PH_ST1: begin
          sda_out_next    = 1'b0;
          wait_count_next = long_load;
          phase_next      = PH_ST2;
        end
        PH_ST2: begin
          scl_out_next = 1'b0;
          done_next    = 1'b1;
          phase_next   = PH_IDLE;
        end
        PH_SP1: begin
          scl_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_SP2;
        end
        PH_SP2: begin
          sda_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_FIN;
        end
        PH_FIN: begin
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_WB0: begin
          sda_out_next    = act_shift[7];
          shift_reg_next  = {act_shift[6:0], 1'b0};
          wait_count_next = short_load;
          phase_next      = PH_WB1;
        end
        PH_WB1: begin
          scl_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_WB2;
        end
        PH_WB2: begin
          scl_out_next    = 1'b0;
          bit_index_next  = bit_inc;
          wait_count_next = short_load;
          phase_next      = (bit_inc >= BITS_PER_BYTE) ? PH_WA0 : PH_WB0;
        end
        PH_WA0: begin
          sda_out_next    = 1'b1;
          wait_count_next = short_load;
          phase_next      = PH_WA1;
        end
        PH_WA1: begin
          scl_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_WA2;
        end
        PH_WA2: begin
          ack_flag_next   = cmd.sda_sample;
          scl_out_next    = 1'b0;
          wait_count_next = short_load;
          phase_next      = PH_FIN;
        end
        PH_RB1: begin
          scl_out_next    = 1'b1;
          wait_count_next = short_load;
          phase_next      = PH_RB2;
        end
        PH_RB2: begin
          shift_reg_next  = {act_shift[6:0], cmd.sda_sample};
          bit_index_next  = bit_inc;
          scl_out_next    = 1'b0;
          wait_count_next = short_load;
          if (bit_inc >= BITS_PER_BYTE) begin
            // last bit in, drive ack or nack in the same tick
            rx_hold_next = {act_shift[6:0], cmd.sda_sample};
            sda_out_next = !ack_latch;
            phase_next   = PH_RA1;
          end else begin
            phase_next = PH_RB1;
          end
        end
        PH_RA1: begin
          scl_out_next    = 1'b1;
          wait_count_next = long_load;
          phase_next      = PH_RA2;
        end
        PH_RA2: begin
          scl_out_next    = 1'b0;
          wait_count_next = short_load;
          phase_next      = PH_FIN;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign res.scl_level     = scl_out_next;
  assign res.sda_release   = sda_out_next;
  assign res.busy_res      = (phase_next != PH_IDLE);
  assign res.done_res      = done_next;
  assign res.rx_byte       = rx_hold_next;
  assign res.nack_received = ack_flag_next;

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BITS_PER_BYTE)
    else $error("bit counter past one byte");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == PH_IDLE)
    else $error("done without returning to idle");

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    step && phase != PH_IDLE && wait_count != 8'd0
    |=> phase == $past(phase) && scl_out == $past(scl_out) && sda_out == $past(sda_out))
    else $error("lines or phase moved during a wait");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && cmd.operation != OP_START && cmd.operation != OP_STOP
    && cmd.operation != OP_WRITE && cmd.operation != OP_READ |=> phase == PH_IDLE)
    else $error("left idle without a command");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |-> phase != PH_IDLE)
    else $error("done pulse while idle");

endmodule

FILE: rtl/i2c_master_byte_engine_core.sv
// a taken tick word is registered in cmd_q, and its report word in res_q once the output register is free
// throughput: one tick word per cycle, limited only by report backpressure
// the bus sequencer advances one step per tick word
// reset (rst, synchronous): lines released high, sequencer idle, waits 2 and 5
// ticks, received byte and ack status cleared, no words in flight
module i2c_master_byte_engine_core (
  input  logic            clk,
  input  logic            rst,
  i2cm_tick_if.sink       tick,
  i2cm_report_if.source   report,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import i2cm_pkg::*;

  cfg_t cfg;
  cmd_t cmd_q;
  logic cmd_vld;
  res_t res;
  res_t res_q;
  logic res_vld;
  logic advance;
  logic step;

  i2cm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .res  (res)
  );

  // output register frees up when empty or being taken
  assign advance    = !res_vld || report.ready;
  assign tick.ready = !cmd_vld || advance;
  assign step       = cmd_vld && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      if (tick.ready) cmd_vld <= tick.valid;
      if (advance) res_vld <= cmd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      cmd_q.operation  <= tick.operation;
      cmd_q.tx_byte    <= tick.tx_byte;
      cmd_q.send_ack   <= tick.send_ack;
      cmd_q.sda_sample <= tick.sda_sample;
    end
    if (step) res_q <= res;
  end

  assign report.valid         = res_vld;
  assign report.scl_level     = res_q.scl_level;
  assign report.sda_release   = res_q.sda_release;
  assign report.busy_res      = res_q.busy_res;
  assign report.done_res      = res_q.done_res;
  assign report.rx_byte       = res_q.rx_byte;
  assign report.nack_received = res_q.nack_received;

endmodule

FILE: tb/tb_i2c_master_byte_engine_core.sv
module tb_i2c_master_byte_engine_core;
  import i2cm_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_LAST         = 3'd7;
  localparam logic [2:0] ADDR_SHORT      = {REG_SHORT, 2'b00};
  localparam logic [2:0] ADDR_LONG       = {REG_LONG, 2'b00};

  // lines released, nothing running, status cleared
  localparam res_t WORD_IDLE  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  // first tick of a start from idle: both lines released, busy
  localparam res_t WORD_START = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  typedef struct {
    cmd_t cmd;
    bit   drain;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cm_tick_if   tick_bus ();
  i2cm_report_if report_bus ();

  i2c_master_byte_engine_core uut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_bus),
    .report (report_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  res_t     words_due[$];
  res_t     due_word;
  dir_row_t plan[$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  bit       bus_open = 1'b0;

  // predictor state
  logic [7:0] cfg_short;
  logic [7:0] cfg_long;
  phase_t     pr_phase;
  logic [7:0] pr_wait;
  logic [3:0] pr_bits;
  logic [7:0] pr_shift;
  logic [7:0] pr_rx;
  logic       pr_ack;
  logic       pr_ack_req;
  logic       pr_scl;
  logic       pr_sda;
  logic       pr_done;

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("mismatch on %s: got 'h%0h, want 'h%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic void arm_wait(input logic [7:0] ticks);
    pr_wait = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
  endfunction

  function automatic void advance(input logic sda_in);
    case (pr_phase)
      PH_ST1: begin
        pr_sda = 1'b0;
        arm_wait(cfg_long);
        pr_phase = PH_ST2;
      end
      PH_ST2: begin
        pr_scl = 1'b0;
        pr_done = 1'b1;
        pr_phase = PH_IDLE;
      end
      PH_SP1: begin
        pr_scl = 1'b1;
        arm_wait(cfg_long);
        pr_phase = PH_SP2;
      end
      PH_SP2: begin
        pr_sda = 1'b1;
        arm_wait(cfg_long);
        pr_phase = PH_FIN;
      end
      PH_FIN: begin
        pr_done = 1'b1;
        pr_phase = PH_IDLE;
      end
      PH_WB0: begin
        pr_sda = pr_shift[7];
        pr_shift = {pr_shift[6:0], 1'b0};
        arm_wait(cfg_short);
        pr_phase = PH_WB1;
      end
      PH_WB1: begin
        pr_scl = 1'b1;
        arm_wait(cfg_long);
        pr_phase = PH_WB2;
      end
      PH_WB2: begin
        pr_scl = 1'b0;
        pr_bits = pr_bits + 4'd1;
        arm_wait(cfg_short);
        pr_phase = (pr_bits >= BITS_PER_BYTE) ? PH_WA0 : PH_WB0;
      end
      PH_WA0: begin
        pr_sda = 1'b1;
        arm_wait(cfg_short);
        pr_phase = PH_WA1;
      end
      PH_WA1: begin
        pr_scl = 1'b1;
        arm_wait(cfg_long);
        pr_phase = PH_WA2;
      end
      PH_WA2: begin
        pr_ack = sda_in;
        pr_scl = 1'b0;
        arm_wait(cfg_short);
        pr_phase = PH_FIN;
      end
      PH_RB1: begin
        pr_scl = 1'b1;
        arm_wait(cfg_short);
        pr_phase = PH_RB2;
      end
      PH_RB2: begin
        pr_shift = {pr_shift[6:0], sda_in};
        pr_bits = pr_bits + 4'd1;
        pr_scl = 1'b0;
        arm_wait(cfg_short);
        if (pr_bits >= BITS_PER_BYTE) begin
          // ack or nack goes out on the same tick as the last sample
          pr_rx = pr_shift;
          pr_sda = ~pr_ack_req;
          pr_phase = PH_RA1;
        end else begin
          pr_phase = PH_RB1;
        end
      end
      PH_RA1: begin
        pr_scl = 1'b1;
        arm_wait(cfg_long);
        pr_phase = PH_RA2;
      end
      PH_RA2: begin
        pr_scl = 1'b0;
        arm_wait(cfg_short);
        pr_phase = PH_FIN;
      end
      default: pr_phase = PH_IDLE;
    endcase
  endfunction

  function automatic res_t bus_step(input cmd_t c);
    res_t r;
    pr_done = 1'b0;
    if (pr_phase == PH_IDLE) begin
      if (c.operation >= OP_START && c.operation <= OP_READ) pr_bits = 4'd0;
      case (c.operation)
        OP_START: begin
          pr_sda = 1'b1;
          pr_scl = 1'b1;
          arm_wait(cfg_long);
          pr_phase = PH_ST1;
        end
        OP_STOP: begin
          pr_scl = 1'b0;
          pr_sda = 1'b0;
          arm_wait(cfg_long);
          pr_phase = PH_SP1;
        end
        OP_WRITE: begin
          pr_shift = c.tx_byte;
          pr_phase = PH_WB0;
          advance(c.sda_sample);
        end
        OP_READ: begin
          pr_ack_req = c.send_ack;
          pr_shift = 8'h00;
          pr_scl = 1'b0;
          pr_sda = 1'b1;
          arm_wait(cfg_short);
          pr_phase = PH_RB1;
        end
        default: ;
      endcase
    end else if (pr_wait != 8'd0) begin
      pr_wait = pr_wait - 8'd1;
    end else begin
      advance(c.sda_sample);
    end
    r.scl_level     = pr_scl;
    r.sda_release   = pr_sda;
    r.busy_res      = (pr_phase != PH_IDLE);
    r.done_res      = pr_done;
    r.rx_byte       = pr_rx;
    r.nack_received = pr_ack;
    return r;
  endfunction

  function automatic int idle_span();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly well-formed transactions, with noise and broken sequences
  function automatic cmd_t next_word();
    cmd_t c;
    int   r;
    c.tx_byte    = 8'($urandom);
    c.send_ack   = 1'($urandom);
    c.sda_sample = 1'($urandom);
    r = $urandom_range(0, 99);
    if (pr_phase != PH_IDLE)
      c.operation = (r < 8) ? 3'($urandom_range(OP_START, OP_LAST)) : OP_TICK;
    else if (r < 12)
      c.operation = (r < 4) ? OP_TICK : 3'($urandom_range(OP_UNUSED_FIRST, OP_LAST));
    else if (!bus_open)
      c.operation = (r < 22) ? 3'($urandom_range(OP_STOP, OP_READ)) : OP_START;
    else if (r < 50)
      c.operation = OP_WRITE;
    else if (r < 80)
      c.operation = OP_READ;
    else if (r < 85)
      c.operation = OP_START;
    else
      c.operation = OP_STOP;
    if (pr_phase == PH_IDLE && c.operation == OP_START) bus_open = 1'b1;
    else if (pr_phase == PH_IDLE && c.operation == OP_STOP) bus_open = 1'b0;
    return c;
  endfunction

  function automatic dir_row_t plan_row(input logic [2:0] op, input logic [7:0] tx,
                                        input logic ack, input logic sda,
                                        input bit drain, input bit typed,
                                        input res_t want);
    dir_row_t d;
    d.cmd.operation  = op;
    d.cmd.tx_byte    = tx;
    d.cmd.send_ack   = ack;
    d.cmd.sda_sample = sda;
    d.drain = drain;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  task automatic put_tick(input cmd_t c, input bit typed, input res_t want);
    res_t predicted;
    int   gap;
    @(negedge clk);
    tick_bus.valid      <= 1'b1;
    tick_bus.operation  <= c.operation;
    tick_bus.tx_byte    <= c.tx_byte;
    tick_bus.send_ack   <= c.send_ack;
    tick_bus.sda_sample <= c.sda_sample;
    do @(posedge clk); while (!tick_bus.ready);
    predicted = bus_step(c);
    words_due.push_back(typed ? want : predicted);
    gap = idle_span();
    if (gap > 0) begin
      @(negedge clk) tick_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_bus();
    while (pr_phase != PH_IDLE) put_tick(next_word(), 1'b0, '0);
  endtask

  task automatic pause_for_drain();
    @(negedge clk) tick_bus.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic wait_reg(input logic [2:0] addr, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, value};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) flag_mismatch("register readback", prdata[7:0], value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_waits(input logic [7:0] short_ticks, input logic [7:0] long_ticks);
    wait_reg(ADDR_SHORT, short_ticks);
    wait_reg(ADDR_LONG, long_ticks);
    cfg_short = short_ticks;
    cfg_long  = long_ticks;
  endtask

  task automatic run_phase(input logic [7:0] short_ticks, input logic [7:0] long_ticks,
                           input int count, input bit quiet);
    set_waits(short_ticks, long_ticks);
    steady = quiet;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) pause_for_drain();
      put_tick(next_word(), 1'b0, '0);
    end
    drain_bus();
    pause_for_drain();
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && report_bus.valid && report_bus.ready) begin
      if (words_due.size() == 0) begin
        flag_mismatch("unexpected word", 8'h00, 8'h00);
      end else begin
        due_word = words_due.pop_front();
        if (report_bus.scl_level !== due_word.scl_level)
          flag_mismatch("scl_level", 8'(report_bus.scl_level), 8'(due_word.scl_level));
        if (report_bus.sda_release !== due_word.sda_release)
          flag_mismatch("sda_release", 8'(report_bus.sda_release),
                        8'(due_word.sda_release));
        if (report_bus.busy_res !== due_word.busy_res)
          flag_mismatch("busy_res", 8'(report_bus.busy_res), 8'(due_word.busy_res));
        if (report_bus.done_res !== due_word.done_res)
          flag_mismatch("done_res", 8'(report_bus.done_res), 8'(due_word.done_res));
        if (report_bus.rx_byte !== due_word.rx_byte)
          flag_mismatch("rx_byte", report_bus.rx_byte, due_word.rx_byte);
        if (report_bus.nack_received !== due_word.nack_received)
          flag_mismatch("nack_received", 8'(report_bus.nack_received),
                        8'(due_word.nack_received));
      end
    end
  end

  // receiver: random stalls between runs of ready
  initial begin
    int stall;
    int run;
    report_bus.ready = 1'b0;
    forever begin
      stall = idle_span();
      if (stall > 0) begin
        @(negedge clk) report_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      run = $urandom_range(1, 24);
      @(negedge clk) report_bus.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
    end
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    tick_bus.valid      = 1'b0;
    tick_bus.operation  = OP_TICK;
    tick_bus.tx_byte    = 8'h00;
    tick_bus.send_ack   = 1'b0;
    tick_bus.sda_sample = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = ADDR_SHORT;
    pwdata              = 32'd0;
    cfg_short  = SHORT_RESET;
    cfg_long   = LONG_RESET;
    pr_phase   = PH_IDLE;
    pr_wait    = 8'd0;
    pr_bits    = 4'd0;
    pr_shift   = 8'h00;
    pr_rx      = 8'h00;
    pr_ack     = 1'b0;
    pr_ack_req = 1'b0;
    pr_scl     = 1'b1;
    pr_sda     = 1'b1;
    pr_done    = 1'b0;

    // reset values, unused codes, every command, extremes of the byte,
    // a write between reads, and commands issued while busy
    plan.push_back(plan_row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, WORD_IDLE));
    plan.push_back(plan_row(OP_UNUSED_FIRST, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, WORD_IDLE));
    plan.push_back(plan_row(OP_UNUSED_FIRST + 3'd1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                            WORD_IDLE));
    plan.push_back(plan_row(OP_LAST, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, WORD_IDLE));
    plan.push_back(plan_row(OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, WORD_START));
    plan.push_back(plan_row(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_READ, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_READ, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_WRITE, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_READ, 8'h01, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_START, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(OP_WRITE, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(plan_row(OP_READ, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_READ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_WRITE, 8'hC3, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(plan_row(OP_STOP, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, '0));

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      put_tick(plan[i].cmd, plan[i].typed, plan[i].want);
      if (plan[i].drain) drain_bus();
    end
    pause_for_drain();

    run_phase(8'd1, 8'd1, 50, 1'b0);
    run_phase(8'd0, 8'd0, 50, 1'b0);
    run_phase(8'd3, 8'd1, 50, 1'b1);
    run_phase(8'd1, 8'd4, 50, 1'b0);
    run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 50, 1'b0);
    run_phase(8'd2, 8'd3, 50, 1'b0);

    // widest waits: a start, then ticks well into its first wait
    set_waits(8'd255, 8'd255);
    put_tick('{operation: OP_START, tx_byte: 8'h00, send_ack: 1'b0, sda_sample: 1'b1},
             1'b0, '0);
    repeat (40) put_tick(next_word(), 1'b0, '0);
    pause_for_drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
